// ----- design/direct_mapped_string_key_table_defines.svh -----
// ----------------------------------------------------------------------------
// direct_mapped_string_key_table_defines.svh
// assertion macros for the key table block
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_STRING_KEY_TABLE_DEFINES_SVH
`define DIRECT_MAPPED_STRING_KEY_TABLE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define DMKT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmkt assertion failed");
// next-cycle implication
`define DMKT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmkt assertion failed");
`else
`define DMKT_ASSERT_IMP(lbl, ante, cons)
`define DMKT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- design/dmkt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkt_pkg
// types, field widths, operation codes and helpers of the key table
// ----------------------------------------------------------------------------
package dmkt_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 5;
  localparam int HASH_W  = 32;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    TS_CLEAR,
    TS_IDLE,
    TS_HASH,
    TS_READ,
    TS_LOOKUP
  } top_state_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_ADD,
    HS_MUL,
    HS_ABS,
    HS_REC,
    HS_REM
  } hash_state_t;

  function automatic logic [5:0] popcount32(input logic [HASH_W-1:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < HASH_W; i++) begin
      n = n + 6'(x[i]);
    end
    return n;
  endfunction

endpackage

// ----- design/dmkt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkt_in_if
// request channel: operation, key and write value
// ----------------------------------------------------------------------------
interface dmkt_in_if;
  logic                          valid;
  logic                          ready;
  logic [dmkt_pkg::KIND_W-1:0]   kind;
  logic [dmkt_pkg::KEY_W-1:0]    key_bytes;
  logic [dmkt_pkg::LEN_W-1:0]    key_length;
  logic [dmkt_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, kind, key_bytes, key_length, write_value, input ready);
  modport sink   (input valid, kind, key_bytes, key_length, write_value, output ready);
endinterface

// ----- design/dmkt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkt_out_if
// response channel: status flag, read value and entry count
// ----------------------------------------------------------------------------
interface dmkt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [dmkt_pkg::VALUE_W-1:0]  read_value;
  logic [dmkt_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, ok, read_value, entry_count, input ready);
  modport sink   (input valid, ok, read_value, entry_count, output ready);
endinterface

// ----- design/dmkt_hash_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkt_hash_core
// iterative key hash and slot index: one add/popcount/xor step and one
// multiply per key byte, then magnitude and, when TABLE_SIZE is not a power of two, a reciprocal-multiply remainder
// ----------------------------------------------------------------------------
module dmkt_hash_core #(
  parameter int TABLE_SIZE    = 16,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [8*MAX_KEY_BYTES-1:0]          key,
  input  logic [dmkt_pkg::LEN_W-1:0]          len,
  output logic                                done,
  output logic [$clog2(TABLE_SIZE)-1:0]       idx
);
  import dmkt_pkg::*;

  localparam int  KW   = 8 * MAX_KEY_BYTES;
  localparam int  IW   = $clog2(TABLE_SIZE);
  localparam bit  POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  // reciprocal ceil(2^(32+IW) / TABLE_SIZE); its bit 32 is always set
  localparam logic [2*HASH_W-1:0] REC_M =
    (((2*HASH_W)'(1) << (HASH_W + IW)) + (2*HASH_W)'(TABLE_SIZE - 1)) /
    (2*HASH_W)'(TABLE_SIZE);
  localparam logic [HASH_W-1:0]   REC_LO = REC_M[HASH_W-1:0];

  hash_state_t          state_r, state_nxt;
  logic [HASH_W-1:0]    h_r, h_nxt;
  logic [HASH_W-1:0]    t_r, t_nxt;
  logic [KW-1:0]        key_sh_r, key_sh_nxt;
  logic [LEN_W-1:0]     left_r, left_nxt;
  logic [HASH_W-1:0]    mag_r, mag_nxt;
  logic [HASH_W-1:0]    q_r, q_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 done_r, done_nxt;

  logic [HASH_W-1:0]    v;
  logic [HASH_W-1:0]    s1;
  logic [HASH_W-1:0]    s2;
  logic [HASH_W-1:0]    mul_a;
  logic [HASH_W-1:0]    mul_b;
  logic [2*HASH_W-1:0]  prod;
  logic [HASH_W-1:0]    neg;
  logic [2*HASH_W:0]    rec_sum;
  logic [HASH_W-1:0]    rem;

  // shared datapath
  assign v    = {{(HASH_W-8){key_sh_r[7]}}, key_sh_r[7:0]};
  assign s1   = h_r + v;
  assign s2   = s1 + HASH_W'(popcount32(s1));
  assign neg  = h_r[HASH_W-1] ? (HASH_W'(0) - h_r) : h_r;

  always_comb begin
    case (state_r)
      HS_REC: begin
        mul_a = mag_r;
        mul_b = REC_LO;
      end
      HS_REM: begin
        mul_a = q_r;
        mul_b = HASH_W'(TABLE_SIZE);
      end
      default: begin
        mul_a = t_r;
        mul_b = v;
      end
    endcase
  end

  // 32x32 full product
  assign prod    = (2*HASH_W)'(mul_a) * (2*HASH_W)'(mul_b);
  assign rec_sum = {1'b0, prod} + {1'b0, mag_r, {HASH_W{1'b0}}};
  assign rem     = mag_r - prod[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r       <= h_nxt;
    t_r       <= t_nxt;
    key_sh_r  <= key_sh_nxt;
    left_r    <= left_nxt;
    mag_r     <= mag_nxt;
    q_r       <= q_nxt;
    idx_r     <= idx_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    h_nxt       = h_r;
    t_nxt       = t_r;
    key_sh_nxt  = key_sh_r;
    left_nxt    = left_r;
    mag_nxt     = mag_r;
    q_nxt       = q_r;
    idx_nxt     = idx_r;
    done_nxt    = 1'b0;
    unique case (state_r)
      HS_IDLE: begin
        if (start) begin
          h_nxt      = '0;
          key_sh_nxt = key;
          left_nxt   = len;
          state_nxt  = (len == '0) ? HS_ABS : HS_ADD;
        end
      end
      HS_ADD: begin
        t_nxt     = s2 ^ v;
        state_nxt = HS_MUL;
      end
      HS_MUL: begin
        h_nxt      = prod[HASH_W-1:0];
        key_sh_nxt = key_sh_r >> 8;
        left_nxt   = left_r - LEN_W'(1);
        state_nxt  = (left_r == LEN_W'(1)) ? HS_ABS : HS_ADD;
      end
      HS_ABS: begin
        mag_nxt = neg;
        if (POW2) begin
          idx_nxt   = neg[IW-1:0];
          done_nxt  = 1'b1;
          state_nxt = HS_IDLE;
        end else begin
          state_nxt = HS_REC;
        end
      end
      HS_REC: begin
        q_nxt     = HASH_W'(rec_sum >> (HASH_W + IW));
        state_nxt = HS_REM;
      end
      HS_REM: begin
        idx_nxt   = rem[IW-1:0];
        done_nxt  = 1'b1;
        state_nxt = HS_IDLE;
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule

// ----- design/direct_mapped_string_key_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_string_key_table
// direct-mapped key/value table with one slot per hash index
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request item: kind (add, find, remove), a key of up to
//   MAX_KEY_BYTES bytes with its length, and the value for add. out_ch returns
//   one item per request: ok, the value read on a find hit, the entry count.
//   both channels move an item when valid and ready are high at a clock edge.
// timing:
//   a request is taken only while the block is idle. the hash unit runs an add
//   step and then a multiply step per key byte, a magnitude step, and a
//   reciprocal step and a remainder step when TABLE_SIZE is not a power of two;
//   then it hands over the index, the slot is read, and the lookup and write
//   follow. a new request can be taken in the cycle after the result is
//   registered.
// reset:
//   synchronous, active low. after reset a clearing pass writes each slot in
//   turn and empties every slot; in_ch.ready stays low meanwhile.
// stalls:
//   the result waits in the output register while out_ch.ready is low; the next
//   request may be taken and hashed, and holds at lookup until the result is gone.
// ----------------------------------------------------------------------------
`include "direct_mapped_string_key_table_defines.svh"

module direct_mapped_string_key_table #(
  parameter int TABLE_SIZE    = 16,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  dmkt_in_if.sink     in_ch,
  dmkt_out_if.source  out_ch
);
  import dmkt_pkg::*;

  localparam int KW = 8 * MAX_KEY_BYTES;
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int EW = 1 + LEN_W + KW + VALUE_W;

  // entry layout: {valid, len, key, value}
  localparam int E_VAL_LO = 0;
  localparam int E_KEY_LO = VALUE_W;
  localparam int E_LEN_LO = VALUE_W + KW;
  localparam int E_VLD    = VALUE_W + KW + LEN_W;

  top_state_t             state_r, state_nxt;
  logic [IW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [LEN_W-1:0]       len_r;
  logic [KW-1:0]          key_r;
  logic [VALUE_W-1:0]     wval_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   ok_r, ok_nxt;
  logic [VALUE_W-1:0]     rval_r, rval_nxt;
  logic [COUNT_W-1:0]     ocnt_r, ocnt_nxt;

  logic [EW-1:0]          mem [TABLE_SIZE];
  logic [EW-1:0]          rd_data_r;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;

  logic                   accept;
  logic [LEN_W-1:0]       len_sat;
  logic [KW-1:0]          key_masked;
  logic                   hash_done;
  logic [IW-1:0]          hash_idx;

  logic                   e_valid;
  logic [LEN_W-1:0]       e_len;
  logic [KW-1:0]          e_key;
  logic [VALUE_W-1:0]     e_value;
  logic                   hit;
  logic                   out_free;
  logic [CW+COUNT_W-1:0]  cnt_ext;

  // request decode
  assign accept  = in_ch.valid && in_ch.ready;
  assign len_sat = (in_ch.key_length > LEN_W'(MAX_KEY_BYTES)) ?
                   LEN_W'(MAX_KEY_BYTES) : in_ch.key_length;

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      key_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? in_ch.key_bytes[8*i +: 8] : 8'h00;
    end
  end

  dmkt_hash_core #(
    .TABLE_SIZE    (TABLE_SIZE),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (key_masked),
    .len   (len_sat),
    .done  (hash_done),
    .idx   (hash_idx)
  );

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[hash_idx];
  end

  assign e_valid = rd_data_r[E_VLD];
  assign e_len   = rd_data_r[E_LEN_LO +: LEN_W];
  assign e_key   = rd_data_r[E_KEY_LO +: KW];
  assign e_value = rd_data_r[E_VAL_LO +: VALUE_W];
  assign hit     = e_valid && (e_len == len_r) && (e_key == key_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_ch.kind;
      len_r  <= len_sat;
      key_r  <= key_masked;
      wval_r <= in_ch.write_value;
    end
    ok_r   <= ok_nxt;
    rval_r <= rval_nxt;
    ocnt_r <= ocnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ok_nxt        = ok_r;
    rval_nxt      = rval_r;
    ocnt_nxt      = ocnt_r;
    wr_en         = 1'b0;
    wr_addr       = hash_idx;
    wr_data       = {1'b1, len_r, key_r, wval_r};
    cnt_ext       = '0;
    unique case (state_r)
      TS_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(TABLE_SIZE - 1)) begin
          state_nxt = TS_IDLE;
        end
      end
      TS_IDLE: begin
        if (accept) begin
          state_nxt = TS_HASH;
        end
      end
      TS_HASH: begin
        if (hash_done) begin
          state_nxt = TS_READ;
        end
      end
      TS_READ: begin
        state_nxt = TS_LOOKUP;
      end
      TS_LOOKUP: begin
        if (out_free) begin
          ok_nxt   = 1'b0;
          rval_nxt = '0;
          unique case (kind_r)
            KIND_ADD: begin
              if (!e_valid) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                ok_nxt  = 1'b1;
              end else if (hit) begin
                wr_en  = 1'b1;
                ok_nxt = 1'b1;
              end
            end
            KIND_FIND: begin
              if (hit) begin
                rval_nxt = e_value;
                ok_nxt   = 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (hit) begin
                wr_en   = 1'b1;
                wr_data = '0;
                cnt_nxt = cnt_r - CW'(1);
                ok_nxt  = 1'b1;
              end
            end
            default: ok_nxt = 1'b0;
          endcase
          cnt_ext       = {{COUNT_W{1'b0}}, cnt_nxt};
          ocnt_nxt      = cnt_ext[COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = TS_IDLE;
        end
      end
      default: state_nxt = TS_IDLE;
    endcase
  end

  assign in_ch.ready        = (state_r == TS_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = ok_r;
  assign out_ch.read_value  = rval_r;
  assign out_ch.entry_count = ocnt_r;

  `DMKT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CW'(TABLE_SIZE))
  `DMKT_ASSERT_IMP(a_wr_state, wr_en, (state_r == TS_CLEAR) || (state_r == TS_LOOKUP))
  `DMKT_ASSERT_NXT(a_accept_hash, accept, state_r == TS_HASH)
  `DMKT_ASSERT_IMP(a_out_from_lookup, $rose(out_valid_r), $past(state_r) == TS_LOOKUP)

endmodule

// ----- sim/tb_direct_mapped_string_key_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_string_key_table
// self-checking bench for the direct-mapped string key table
// ----------------------------------------------------------------------------
// a directed sequence walks through empty keys, high-bit characters, length
// saturation, stray key bytes, updates, collisions, misses and the unused
// kind. a random run follows on a key pool that covers every slot, mixed with
// noise items. a local copy of the table predicts every result. requests go
// out in bursts with random gaps, and the result side stalls in phases.
// ----------------------------------------------------------------------------
module tb_direct_mapped_string_key_table;
  import dmkt_pkg::*;

  localparam int TABLE_SIZE    = 16;
  localparam int MAX_KEY_BYTES = 8;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int POOL_SIZE     = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
  } response_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } table_key_t;

  logic clk;
  logic rst_n;

  dmkt_in_if  in_ch ();
  dmkt_out_if out_ch ();

  direct_mapped_string_key_table #(
    .TABLE_SIZE    (TABLE_SIZE),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // table copy
  logic               slot_used  [TABLE_SIZE] = '{default: 1'b0};
  logic [KEY_W-1:0]   slot_key   [TABLE_SIZE] = '{default: '0};
  logic [LEN_W-1:0]   slot_len   [TABLE_SIZE] = '{default: '0};
  logic [VALUE_W-1:0] slot_value [TABLE_SIZE] = '{default: '0};
  int unsigned        occupied = 0;

  request_t    pending_q[$];
  response_t   response_q[$];
  int unsigned accepted_count = 0;
  int unsigned total_items    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          failed         = 1'b0;

  int unsigned burst_left      = 1;
  int unsigned gap_left        = 0;
  int unsigned stall_mode      = 0;
  int unsigned stall_mode_left = 0;

  function automatic int unsigned clamp_len(logic [LEN_W-1:0] len);
    return (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len);
  endfunction

  function automatic logic [KEY_W-1:0] mask_key(logic [KEY_W-1:0] key, int unsigned len);
    return (len >= 8) ? key : key & ((64'd1 << (len * 8)) - 64'd1);
  endfunction

  // per byte, sign extended: add, add popcount, xor, multiply
  function automatic int unsigned hash_slot(logic [KEY_W-1:0] key, int unsigned len);
    logic [31:0] h;
    logic [31:0] v;
    h = '0;
    for (int i = 0; i < len; i++) begin
      v = {{24{key[8*i+7]}}, key[8*i +: 8]};
      h = h + v;
      h = h + 32'($countones(h));
      h = h ^ v;
      h = h * v;
    end
    if (h[31]) h = -h;
    return h % TABLE_SIZE;
  endfunction

  function automatic response_t apply_request(request_t req);
    response_t        rsp;
    int unsigned      len;
    int unsigned      idx;
    logic [KEY_W-1:0] key;
    logic             hit;
    len = clamp_len(req.len);
    key = mask_key(req.key, len);
    idx = hash_slot(key, len);
    hit = slot_used[idx] && slot_len[idx] == len && slot_key[idx] == key;
    rsp = '0;
    case (req.kind)
      KIND_ADD: begin
        if (!slot_used[idx]) begin
          slot_used[idx]  = 1'b1;
          slot_key[idx]   = key;
          slot_len[idx]   = LEN_W'(len);
          slot_value[idx] = req.value;
          occupied++;
          rsp.ok = 1'b1;
        end else if (hit) begin
          slot_value[idx] = req.value;
          rsp.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        if (hit) begin
          rsp.read_value = slot_value[idx];
          rsp.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          slot_used[idx]  = 1'b0;
          slot_key[idx]   = '0;
          slot_len[idx]   = '0;
          slot_value[idx] = '0;
          occupied--;
          rsp.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = occupied[COUNT_W-1:0];
    return rsp;
  endfunction

  function automatic table_key_t key_for_slot(int unsigned idx);
    table_key_t entry;
    do begin
      entry.len = LEN_W'($urandom_range(1, MAX_KEY_BYTES));
      entry.key = mask_key({$urandom, $urandom}, entry.len);
    end while (hash_slot(entry.key, entry.len) != idx);
    return entry;
  endfunction

  task automatic push_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [LEN_W-1:0] len, logic [VALUE_W-1:0] value);
    request_t req;
    req.kind  = kind;
    req.key   = key;
    req.len   = len;
    req.value = value;
    pending_q.push_back(req);
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ADD;
    in_ch.key_bytes    = '0;
    in_ch.key_length   = '0;
    in_ch.write_value  = '0;
    out_ch.ready       = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req.kind  = in_ch.kind;
        req.key   = in_ch.key_bytes;
        req.len   = in_ch.key_length;
        req.value = in_ch.write_value;
        response_q.push_back(apply_request(req));
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req = pending_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.kind        <= req.kind;
          in_ch.key_bytes   <= req.key;
          in_ch.key_length  <= req.len;
          in_ch.write_value <= req.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 9) < 4) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(5, 25);
            else gap_left = $urandom_range(1, 4);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.ok          = out_ch.ok;
        got.read_value  = out_ch.read_value;
        got.entry_count = out_ch.entry_count;
        if (response_q.size() == 0) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: ok=%0d value=%h count=%0d",
                     got.ok, got.read_value, got.entry_count);
        end else begin
          want = response_q.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: expected ok=%0d value=%h count=%0d, got ok=%0d value=%h count=%0d",
                       want.ok, want.read_value, want.entry_count,
                       got.ok, got.read_value, got.entry_count);
          end
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default: out_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  initial begin
    table_key_t         pool [POOL_SIZE];
    table_key_t         entry;
    table_key_t         other;
    logic [KEY_W-1:0]   high_key;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len_field;
    logic [KIND_W-1:0]  kind;
    int unsigned        add_weight;
    int unsigned        roll;
    int unsigned        len;

    // empty key, stray bytes on an empty key
    push_item(KIND_ADD, '0, 4'd0, '1);
    push_item(KIND_FIND, 64'h1234_5678_9abc_def0, 4'd0, '0);
    push_item(KIND_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd0, '0);
    push_item(KIND_REMOVE, '0, 4'd0, '0);

    // all characters with the high bit set, length saturation, update
    high_key = 64'hff80_c3a5_9e81_f0b7;
    push_item(KIND_ADD, high_key, 4'd8, '0);
    push_item(KIND_FIND, high_key, 4'd15, '1);
    push_item(KIND_ADD, high_key, 4'd9, 64'hdead_beef_0bad_f00d);
    push_item(KIND_FIND, high_key, 4'd8, '0);

    // a different key on the same slot
    other = key_for_slot(hash_slot(high_key, MAX_KEY_BYTES));
    push_item(KIND_ADD, other.key | (64'hffff_ffff_ffff_ffff & ~mask_key('1, other.len)),
              other.len, '1);
    push_item(KIND_FIND, other.key, other.len, '0);
    push_item(KIND_REMOVE, other.key, other.len, '0);
    push_item(KIND_NONE, high_key, 4'd8, '1);
    push_item(KIND_FIND, mask_key(high_key, 7), 4'd7, '0);
    push_item(KIND_REMOVE, high_key, 4'd8, '0);
    push_item(KIND_FIND, high_key, 4'd8, '0);

    // positive characters, same bytes with a longer length
    push_item(KIND_ADD, 64'h0000_0000_0000_7f01, 4'd2, 64'h8000_0000_0000_0001);
    push_item(KIND_FIND, 64'h0000_0000_0000_7f01, 4'd3, '0);
    push_item(KIND_FIND, 64'h5a5a_5a5a_5a5a_7f01, 4'd2, '0);
    push_item(KIND_REMOVE, 64'hffff_ffff_ffff_7f01, 4'd2, '1);
    push_item(KIND_NONE, '0, 4'd0, '0);

    // pool: one key per slot, then a few extra keys that collide
    for (int i = 0; i < TABLE_SIZE; i++) pool[i] = key_for_slot(i);
    for (int i = TABLE_SIZE; i < POOL_SIZE; i++) begin
      pool[i].len = LEN_W'($urandom_range(0, MAX_KEY_BYTES));
      pool[i].key = mask_key({$urandom, $urandom}, pool[i].len);
    end

    add_weight = 40;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: add_weight = 15;
          1: add_weight = 40;
          default: add_weight = 65;
        endcase
      end
      if ($urandom_range(0, 99) < 85) begin
        entry     = pool[$urandom_range(0, POOL_SIZE - 1)];
        key       = entry.key;
        len_field = entry.len;
        if ($urandom_range(0, 2) == 0) begin
          key = key | ({$urandom, $urandom} & ~mask_key('1, entry.len));
          if (entry.len == MAX_KEY_BYTES) len_field = LEN_W'($urandom_range(8, 15));
        end
        roll = $urandom_range(0, 99);
        if (roll < add_weight) kind = KIND_ADD;
        else if (roll < 96) kind = ($urandom_range(0, 1) == 0) ? KIND_FIND : KIND_REMOVE;
        else kind = KIND_NONE;
      end else begin
        key       = {$urandom, $urandom};
        len_field = LEN_W'($urandom_range(0, 15));
        kind      = KIND_W'($urandom_range(0, 3));
        if (kind == KIND_ADD && $urandom_range(0, 3) != 0) kind = KIND_FIND;
        if (kind == KIND_ADD) begin
          // keep junk keys reachable so they can be removed later
          len = clamp_len(len_field);
          entry.key = mask_key(key, len);
          entry.len = LEN_W'(len);
          pool[$urandom_range(TABLE_SIZE, POOL_SIZE - 1)] = entry;
        end
      end
      push_item(kind, key, len_field, {$urandom, $urandom});
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_items || response_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/dmkt_pkg.sv
design/dmkt_in_if.sv
design/dmkt_out_if.sv
design/dmkt_hash_core.sv
design/direct_mapped_string_key_table.sv
sim/tb_direct_mapped_string_key_table.sv
